@@ rtl/ffa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffa_pkg: shared types and constants of the first-fit arena allocator
// Request/result payload structs, operation codes and sequencer states.
// ----------------------------------------------------------------------------
package ffa_pkg;

  // Block header: next, previous, total length (32-bit little-endian words)
  localparam int unsigned HDR_BYTES   = 12;
  // Start pointer at offset 0
  localparam int unsigned START_BYTES = 4;
  // Width of internal pointers, wider than a 32-bit header word
  localparam int unsigned PW          = 34;
  // Saturation ceiling of the 13-bit statistics
  localparam int unsigned SAT_MAX     = 8191;

  typedef enum logic [2:0] {
    OP_ALLOC = 3'd0,
    OP_FREE  = 3'd1,
    OP_FILL  = 3'd2,
    OP_FSTAT = 3'd3,
    OP_USTAT = 3'd4,
    OP_READ  = 3'd5
  } op_e;

  typedef struct packed {
    logic [2:0]  op;
    logic [12:0] length;
    logic [11:0] index;
    logic [7:0]  fill_value;
  } ffa_req_t;

  typedef struct packed {
    logic [11:0]        alloc_index;
    logic [12:0]        idle_bytes;
    logic [12:0]        free_regions;
    logic [12:0]        block_count;
    logic [12:0]        data_bytes;
    logic [6:0]         efficiency_pct;
    logic signed [7:0]  fragmentation_pct;
    logic [7:0]         read_data;
  } ffa_res_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DONE,
    ST_RDW,
    ST_WRW,
    ST_MB,
    ST_A_FIRST,
    ST_A_STEP,
    ST_A_NXT,
    ST_A_LEN,
    ST_F_NXT,
    ST_F_PRV,
    ST_F_LINK,
    ST_FILL,
    ST_RDB,
    ST_S_FIRST,
    ST_S_STEP,
    ST_S_LEN,
    ST_S_NXT,
    ST_S_END,
    ST_S_CALC,
    ST_E_SETUP,
    ST_DIV,
    ST_G_SETUP
  } ffa_state_e;

endpackage

@@ rtl/first_fit_arena_allocator_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_arena_allocator_top: first-fit linked block allocator
// Byte arena in one synchronous RAM, walked and updated by a sequencer.
// ----------------------------------------------------------------------------
//  channel   | ports                         | handshake
//  ----------+-------------------------------+------------------------------
//  request   | start, busy, req_i            | taken when start && !busy
//  result    | res_valid_o, res_o            | one-cycle strobe, no stall
//  config    | cfg_we_i, cfg_wdata_i         | written when cfg_we_i
//
//  Every byte access goes through the single RAM port: a header word is
//  read and written one byte at a time. Alloc walks the blocks and then
//  links the new one in; free relinks the neighbours; fill writes at most
//  length bytes; read fetches one byte; statistics walk every block, and
//  usage then runs the divider.
//  After reset a clearing pass over the whole arena runs with busy high.
//  Results cannot be stalled; busy drops in the result cycle.
// ----------------------------------------------------------------------------
module first_fit_arena_allocator_top #(
  parameter int unsigned ARENA_BYTES = 4096
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  ffa_pkg::ffa_req_t req_i,
  output logic             res_valid_o,
  output ffa_pkg::ffa_res_t res_o,
  input  logic             cfg_we_i,
  input  logic [12:0]      cfg_wdata_i
);
  import ffa_pkg::*;

  localparam int unsigned AW  = $clog2(ARENA_BYTES);
  localparam int unsigned STW = $clog2(ARENA_BYTES + 1);
  localparam int unsigned RGW = $clog2(ARENA_BYTES + 2);
  localparam int unsigned LSW = 32 + STW;
  localparam int unsigned DW  = LSW + 1;
  localparam int unsigned NW  = LSW + 7;
  localparam int unsigned RESET_SIZE = (ARENA_BYTES < 4096) ? ARENA_BYTES : 4096;
  localparam logic [AW-1:0] CLR_LAST = AW'(ARENA_BYTES - 1);

  function automatic logic [12:0] sat13(input logic [LSW:0] v);
    if (v > (LSW+1)'(SAT_MAX)) begin
      return 13'(SAT_MAX);
    end
    return v[12:0];
  endfunction

  function automatic logic [NW-1:0] mul100(input logic [NW-1:0] v);
    return (v << 6) + (v << 5) + (v << 2);
  endfunction

  // Control state
  ffa_state_e      state_q, state_d, ret_q, ret_d;
  logic [STW-1:0]  lsz_q, lsz_d;
  logic [AW-1:0]   clr_q;

  // Datapath
  ffa_req_t        req_q;
  ffa_res_t        res_q;
  logic [2:0]      cnt_q;
  logic [PW-1:0]   rba_q, wba_q;
  logic            rv_q;
  logic [31:0]     word_q, wdat_q;
  logic [13:0]     need_q;
  logic [PW-1:0]   cur_q, nxt_q, at_q, prv_q, end_q;
  logic [2:0]      mb_q;
  logic [STW-1:0]  steps_q, blocks_q;
  logic [LSW-1:0]  lensum_q;
  logic [RGW-1:0]  regions_q;
  logic signed [LSW:0] data_q;
  logic [NW-1:0]   rem_q;
  logic [DW-1:0]   dvs_q;
  logic [6:0]      quo_q;
  logic [2:0]      k_q;
  logic            dsel_q, neg_q;
  logic [12:0]     fcnt_q;

  // RAM
  logic [7:0]      mem_q [ARENA_BYTES];
  logic [7:0]      mem_rdata_q;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  logic [7:0]      mem_wdata;

  // Shared comb values
  logic [PW-1:0]   sz_x, word_x, need_x, end_c, rd_addr, wr_addr;
  logic            fit_mid, fit_tail, at_limit, ge;
  logic [1:0]      byte_sel;
  logic [NW-1:0]   dsh;
  logic [6:0]      quo_n;
  logic [DW-1:0]   tot;
  logic [LSW-1:0]  blk12;

  assign sz_x     = PW'(lsz_q);
  assign word_x   = PW'(word_q);
  assign need_x   = PW'(need_q);
  assign end_c    = cur_q + word_x;
  assign rd_addr  = rba_q + PW'(cnt_q);
  assign wr_addr  = wba_q + PW'(cnt_q);
  assign fit_mid  = (end_c <= nxt_q) && ((nxt_q - end_c) >= need_x);
  assign fit_tail = (end_c <= sz_x) && ((sz_x - end_c) >= need_x);
  assign at_limit = (steps_q >= STW'(ARENA_BYTES));
  assign byte_sel = cnt_q[1:0] - 2'd1;
  assign dsh      = NW'(dvs_q) << k_q;
  assign ge       = (rem_q >= dsh);
  assign tot      = DW'(lensum_q) + DW'(START_BYTES);
  assign blk12    = (LSW'(blocks_q) << 3) + (LSW'(blocks_q) << 2);

  always_comb begin
    quo_n      = quo_q;
    quo_n[k_q] = ge;
  end

  // Live arena size, clamped on write
  always_comb begin
    if (cfg_wdata_i < 13'd16) begin
      lsz_d = STW'(16);
    end else if (32'(cfg_wdata_i) > ARENA_BYTES) begin
      lsz_d = STW'(ARENA_BYTES);
    end else begin
      lsz_d = STW'(cfg_wdata_i);
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      ret_q   <= ST_IDLE;
      lsz_q   <= STW'(RESET_SIZE);
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      if (cfg_we_i) begin
        lsz_q <= lsz_d;
      end
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + AW'(1);
      end
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_q == CLR_LAST) state_d = ST_IDLE;
      end
      ST_IDLE, ST_DONE: begin
        state_d = ST_IDLE;
        if (start) begin
          unique case (req_i.op)
            OP_ALLOC: begin
              state_d = ST_RDW;
              ret_d   = ST_A_FIRST;
            end
            OP_FREE: begin
              if (req_i.index < 12'(START_BYTES + HDR_BYTES)) begin
                state_d = ST_DONE;
              end else begin
                state_d = ST_RDW;
                ret_d   = ST_F_NXT;
              end
            end
            OP_FILL: state_d = ST_FILL;
            OP_FSTAT, OP_USTAT: begin
              state_d = ST_RDW;
              ret_d   = ST_S_FIRST;
            end
            OP_READ: begin
              state_d = ST_RDW;
              ret_d   = ST_RDB;
            end
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_RDW: begin
        if (cnt_q == 3'd4) state_d = ret_q;
      end
      ST_WRW: begin
        if (cnt_q == 3'd3) state_d = ret_q;
      end
      ST_MB: begin
        if (mb_q == 3'd5) begin
          state_d = ST_DONE;
        end else if (!(mb_q == 3'd1 && nxt_q == '0)) begin
          state_d = ST_WRW;
          ret_d   = ST_MB;
        end
      end
      ST_A_FIRST: begin
        if (word_q == '0) begin
          state_d = (sz_x < need_x + PW'(START_BYTES)) ? ST_DONE : ST_MB;
        end else if (word_x >= need_x + PW'(START_BYTES)) begin
          state_d = ST_MB;
        end else begin
          state_d = ST_A_STEP;
        end
      end
      ST_A_STEP: begin
        if (at_limit) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_RDW;
          ret_d   = ST_A_NXT;
        end
      end
      ST_A_NXT: begin
        state_d = ST_RDW;
        ret_d   = ST_A_LEN;
      end
      ST_A_LEN: begin
        if (nxt_q == '0) begin
          state_d = fit_tail ? ST_MB : ST_DONE;
        end else begin
          state_d = fit_mid ? ST_MB : ST_A_STEP;
        end
      end
      ST_F_NXT: begin
        state_d = ST_RDW;
        ret_d   = ST_F_PRV;
      end
      ST_F_PRV: begin
        state_d = ST_WRW;
        ret_d   = ST_F_LINK;
      end
      ST_F_LINK: begin
        if (nxt_q != '0) begin
          state_d = ST_WRW;
          ret_d   = ST_DONE;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_FILL: begin
        if (fcnt_q == '0 || cur_q >= sz_x) state_d = ST_DONE;
      end
      ST_RDB: state_d = ST_DONE;
      ST_S_FIRST: begin
        state_d = (word_q == '0) ? ST_S_CALC : ST_S_STEP;
      end
      ST_S_STEP: begin
        if (at_limit) begin
          state_d = ST_S_END;
        end else begin
          state_d = ST_RDW;
          ret_d   = ST_S_LEN;
        end
      end
      ST_S_LEN: begin
        state_d = ST_RDW;
        ret_d   = ST_S_NXT;
      end
      ST_S_NXT: begin
        state_d = (word_q == '0) ? ST_S_END : ST_S_STEP;
      end
      ST_S_END: state_d = ST_S_CALC;
      ST_S_CALC: begin
        state_d = (req_q.op == OP_FSTAT) ? ST_DONE : ST_E_SETUP;
      end
      ST_E_SETUP: state_d = ST_DIV;
      ST_DIV: begin
        if (k_q == '0) state_d = dsel_q ? ST_DONE : ST_G_SETUP;
      end
      ST_G_SETUP: begin
        state_d = (blocks_q == '0) ? ST_DONE : ST_DIV;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs: RAM control and port flags
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_raddr = rd_addr[AW-1:0];
    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
      end
      ST_WRW: begin
        if (wr_addr < sz_x) begin
          mem_we    = 1'b1;
          mem_waddr = wr_addr[AW-1:0];
          mem_wdata = wdat_q[8*cnt_q[1:0] +: 8];
        end
      end
      ST_FILL: begin
        if (fcnt_q != '0 && cur_q < sz_x) begin
          mem_we    = 1'b1;
          mem_waddr = cur_q[AW-1:0];
          mem_wdata = req_q.fill_value;
        end
      end
      default: ;
    endcase
  end

  assign busy        = !(state_q == ST_IDLE || state_q == ST_DONE);
  assign res_valid_o = (state_q == ST_DONE);
  assign res_o       = res_q;

  // Arena RAM, registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= mem_q[mem_raddr];
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    // byte counter of the word read/write sequencer
    cnt_q <= (state_q == ST_RDW || state_q == ST_WRW) ? cnt_q + 3'd1 : 3'd0;
    unique case (state_q)
      ST_IDLE, ST_DONE: begin
        if (start) begin
          req_q  <= req_i;
          res_q  <= '0;
          need_q <= 14'(req_i.length) + 14'(HDR_BYTES);
          cur_q  <= PW'(req_i.index);
          fcnt_q <= req_i.length;
          if (req_i.op == OP_FREE) begin
            rba_q <= PW'(req_i.index) - PW'(HDR_BYTES);
          end else if (req_i.op == OP_READ) begin
            rba_q <= PW'(req_i.index);
          end else begin
            rba_q <= '0;
          end
        end
      end
      ST_RDW: begin
        rv_q <= (rd_addr < sz_x);
        if (cnt_q != 3'd0) begin
          word_q[8*byte_sel +: 8] <= rv_q ? mem_rdata_q : 8'd0;
        end
      end
      ST_MB: begin
        mb_q <= mb_q + 3'd1;
        case (mb_q)
          3'd0: begin
            wba_q  <= prv_q;
            wdat_q <= at_q[31:0];
          end
          3'd1: begin
            wba_q  <= nxt_q + PW'(4);
            wdat_q <= at_q[31:0];
          end
          3'd2: begin
            wba_q  <= at_q;
            wdat_q <= nxt_q[31:0];
          end
          3'd3: begin
            wba_q  <= at_q + PW'(4);
            wdat_q <= prv_q[31:0];
          end
          3'd4: begin
            wba_q  <= at_q + PW'(8);
            wdat_q <= 32'(need_q);
          end
          default: begin
            res_q.alloc_index <= 12'(at_q + PW'(HDR_BYTES));
          end
        endcase
      end
      ST_A_FIRST: begin
        mb_q  <= '0;
        at_q  <= PW'(START_BYTES);
        prv_q <= '0;
        nxt_q <= (word_q == '0) ? '0 : word_x;
        cur_q <= word_x;
        steps_q <= '0;
      end
      ST_A_STEP: rba_q <= cur_q;
      ST_A_NXT: begin
        nxt_q <= word_x;
        rba_q <= cur_q + PW'(8);
      end
      ST_A_LEN: begin
        mb_q  <= '0;
        at_q  <= end_c;
        prv_q <= cur_q;
        cur_q <= nxt_q;
        steps_q <= steps_q + STW'(1);
      end
      ST_F_NXT: begin
        nxt_q <= word_x;
        rba_q <= PW'(req_q.index) - PW'(8);
      end
      ST_F_PRV: begin
        prv_q  <= word_x;
        wba_q  <= word_x;
        wdat_q <= nxt_q[31:0];
      end
      ST_F_LINK: begin
        wba_q  <= nxt_q + PW'(4);
        wdat_q <= prv_q[31:0];
      end
      ST_FILL: begin
        if (fcnt_q != '0 && cur_q < sz_x) begin
          cur_q  <= cur_q + PW'(1);
          fcnt_q <= fcnt_q - 13'd1;
        end
      end
      ST_RDB: res_q.read_data <= word_q[7:0];
      ST_S_FIRST: begin
        cur_q    <= word_x;
        blocks_q <= '0;
        lensum_q <= '0;
        steps_q  <= '0;
        end_q    <= '0;
        regions_q <= (word_q == '0 || word_x > PW'(START_BYTES)) ? RGW'(1) : '0;
      end
      ST_S_STEP: rba_q <= cur_q + PW'(8);
      ST_S_LEN: begin
        blocks_q <= blocks_q + STW'(1);
        lensum_q <= lensum_q + LSW'(word_q);
        end_q    <= end_c;
        rba_q    <= cur_q;
      end
      ST_S_NXT: begin
        if (word_q != '0) begin
          if (end_q < word_x) regions_q <= regions_q + RGW'(1);
          cur_q   <= word_x;
          steps_q <= steps_q + STW'(1);
        end
      end
      ST_S_END: begin
        if (end_q < sz_x) regions_q <= regions_q + RGW'(1);
      end
      ST_S_CALC: begin
        data_q <= $signed({1'b0, lensum_q}) - $signed({1'b0, blk12});
        if (req_q.op == OP_FSTAT) begin
          res_q.free_regions <= sat13((LSW+1)'(regions_q));
          if (tot > DW'(lsz_q)) begin
            res_q.idle_bytes <= '0;
          end else begin
            res_q.idle_bytes <= sat13((LSW+1)'(DW'(lsz_q) - tot));
          end
        end
      end
      ST_E_SETUP: begin
        res_q.block_count <= sat13((LSW+1)'(blocks_q));
        if (data_q > 0) begin
          res_q.data_bytes <= sat13(data_q[LSW:0]);
          rem_q <= mul100(NW'(data_q[LSW-1:0]));
        end else begin
          res_q.data_bytes <= '0;
          rem_q <= '0;
        end
        dvs_q  <= tot;
        quo_q  <= '0;
        k_q    <= 3'd6;
        dsel_q <= 1'b0;
      end
      ST_DIV: begin
        if (ge) rem_q <= rem_q - dsh;
        quo_q <= quo_n;
        k_q   <= k_q - 3'd1;
        if (k_q == '0) begin
          if (!dsel_q) begin
            res_q.efficiency_pct <= quo_n;
          end else begin
            res_q.fragmentation_pct <= neg_q ? -$signed({1'b0, quo_n})
                                             : $signed({1'b0, quo_n});
          end
        end
      end
      ST_G_SETUP: begin
        dsel_q <= 1'b1;
        quo_q  <= '0;
        k_q    <= 3'd6;
        dvs_q  <= DW'(blocks_q);
        neg_q  <= (regions_q == '0);
        // 100 * (regions - 1), or 100 for the no-gap case
        rem_q  <= (regions_q == '0) ? mul100(NW'(1))
                                    : mul100(NW'(regions_q - RGW'(1)));
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/ffa_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffa_checker: port-level checks of the arena allocator
// Sequencing of requests and results and range of the percent outputs.
// ----------------------------------------------------------------------------
module ffa_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              res_valid_o,
  input ffa_pkg::ffa_res_t res_o
);
  import ffa_pkg::*;

  // A result cycle is never busy
  a_res_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !busy)
    else $error("result strobe while busy");

  // No second result without a new request
  a_single_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !(start && !busy)) |=> !res_valid_o)
    else $error("result repeated without request");

  // A taken request keeps the block busy or answers at once
  a_req_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || res_valid_o))
    else $error("request dropped");

  // Percent outputs stay in range
  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_o.efficiency_pct <= 7'd100 &&
                     $signed(res_o.fragmentation_pct) <= 8'sd100 &&
                     $signed(res_o.fragmentation_pct) >= -8'sd100))
    else $error("percent out of range");

endmodule

bind first_fit_arena_allocator_top ffa_checker u_ffa_checker (.*);
